/* design/quaternion_w_completion_q30_assert.svh */
// Assertion macros shared by the quaternion w completion design.
// Depends on nothing; included by modules that check their own logic.
`ifndef QUATERNION_W_COMPLETION_Q30_ASSERT_SVH
`define QUATERNION_W_COMPLETION_Q30_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QWC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/qwc_pkg.sv */
// Types shared by the quaternion w completion pipeline.
// Used by the square root cells, the divider cells and the top level.
`default_nettype none
package qwc_pkg;

  localparam int SqrtCells = 32;

  typedef struct packed {
    logic              vld;
    logic              clamp;
    logic [2:0]        neg;
    logic [2:0][31:0]  raw;
    logic [2:0][31:0]  mag;
  } qwc_tag_t;

  typedef struct packed {
    qwc_tag_t     tag;
    logic [63:0]  rad;
    logic [34:0]  rem;
    logic [31:0]  root;
  } qwc_sq_t;

  typedef struct packed {
    qwc_tag_t          tag;
    logic [31:0]       root;
    logic [2:0][63:0]  rem;
    logic [2:0][31:0]  quo;
  } qwc_dv_t;

endpackage
`default_nettype wire

/* design/qwc_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per cycle while ce is high.
// Depends on qwc_pkg for the cell payload type.
`default_nettype none
module qwc_sqrt_cell
  import qwc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    ce,
  input  wire qwc_sq_t din,
  output qwc_sq_t      dout
);

  logic [34:0] rem2;
  logic [34:0] trial;
  logic        ge;
  qwc_sq_t     dout_next;

  always_comb begin
    rem2  = {din.rem[32:0], din.rad[63:62]};
    trial = {1'b0, din.root, 2'b01};
    ge    = (rem2 >= trial);
    dout_next      = din;
    dout_next.rad  = {din.rad[61:0], 2'b00};
    dout_next.rem  = ge ? (rem2 - trial) : rem2;
    dout_next.root = {din.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.tag.vld <= 1'b0;
    end else if (ce) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

/* design/qwc_div_cell.sv */
// One cell of the divider chain: one quotient bit for each of three lanes.
// Depends on qwc_pkg for the cell payload type.
`default_nettype none
module qwc_div_cell
  import qwc_pkg::*;
#(
  parameter int SH = 30
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    ce,
  input  wire qwc_dv_t din,
  output qwc_dv_t      dout
);

  logic [63:0] dvs;
  logic [2:0]  ge;
  qwc_dv_t     dout_next;

  always_comb begin
    dvs       = {32'd0, din.root} << SH;
    dout_next = din;
    for (int l = 0; l < 3; l++) begin
      ge[l] = (din.rem[l] >= dvs);
      dout_next.rem[l] = ge[l] ? (din.rem[l] - dvs) : din.rem[l];
      dout_next.quo[l] = {din.quo[l][30:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.tag.vld <= 1'b0;
    end else if (ce) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

/* design/quaternion_w_completion_q30.sv */
// Quaternion w completion: forms s = x*x + y*y + z*z; below one, w = sqrt(1 - s) and x, y, z
// pass; otherwise w = 0 and x, y, z are divided by sqrt(s). One sample is taken every cycle
// unless the output stalls. Samples run through the input registers, the 32-cell root chain,
// the FRAC_BITS + 1 cell divider chain and the output register; a stalled output holds them all.
// Depends on qwc_pkg, qwc_sqrt_cell, qwc_div_cell and the assertion header.
`default_nettype none
`include "quaternion_w_completion_q30_assert.svh"
module quaternion_w_completion_q30
  import qwc_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // quat_x, quat_y, quat_z
  input  wire logic         s_axis_tuser,  // quat_valid
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,  // out_x, out_y, out_z, out_w, zero pad
  output logic              m_axis_tuser   // w_clamped
);

  localparam logic [63:0] One     = 64'd1 << (2 * FRAC_BITS);
  localparam int          DivCells = FRAC_BITS + 1;

  logic ce;
  assign ce = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ce;

  qwc_tag_t    tag1, tag2, tag3;
  logic [2:0][63:0] prod;
  logic [63:0] sum;
  qwc_tag_t    tag1_next;

  always_comb begin
    tag1_next       = '0;
    tag1_next.vld   = s_axis_tvalid & s_axis_tuser;
    for (int l = 0; l < 3; l++) begin
      tag1_next.raw[l] = s_axis_tdata[32*l +: 32];
      tag1_next.neg[l] = s_axis_tdata[32*l + 31];
      tag1_next.mag[l] = tag1_next.neg[l] ? (~tag1_next.raw[l] + 32'd1) : tag1_next.raw[l];
    end
  end

  qwc_sq_t sq [0:SqrtCells];
  qwc_sq_t sq0_next;
  qwc_sq_t sq_in;

  always_comb begin
    sq0_next           = '0;
    sq0_next.tag       = tag3;
    sq0_next.tag.clamp = (sum >= One);
    sq0_next.rad       = (sum >= One) ? sum : (One - sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld <= 1'b0;
      tag2.vld <= 1'b0;
      tag3.vld <= 1'b0;
      sq_in.tag.vld <= 1'b0;
    end else if (ce) begin
      tag1 <= tag1_next;
      tag2 <= tag1;
      for (int l = 0; l < 3; l++) begin
        prod[l] <= 64'(tag1.mag[l]) * 64'(tag1.mag[l]);
      end
      tag3 <= tag2;
      sum  <= prod[0] + prod[1] + prod[2];
      sq_in <= sq0_next;
    end
  end

  assign sq[0] = sq_in;

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    qwc_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ce  (ce),
      .din (sq[k]),
      .dout(sq[k+1])
    );
  end

  qwc_dv_t dv [0:DivCells];
  qwc_dv_t dv_in;

  always_comb begin
    dv_in      = '0;
    dv_in.tag  = sq[SqrtCells].tag;
    dv_in.root = sq[SqrtCells].root;
    for (int l = 0; l < 3; l++) begin
      dv_in.rem[l] = {32'd0, sq[SqrtCells].tag.mag[l]} << FRAC_BITS;
    end
  end

  assign dv[0] = dv_in;

  for (genvar k = 0; k < DivCells; k++) begin : g_div
    qwc_div_cell #(.SH(FRAC_BITS - k)) u_cell (
      .clk (clk),
      .rst (rst),
      .ce  (ce),
      .din (dv[k]),
      .dout(dv[k+1])
    );
  end

  qwc_dv_t     fin;
  logic [127:0] tdata_next;

  assign fin = dv[DivCells];

  always_comb begin
    tdata_next = '0;
    for (int l = 0; l < 3; l++) begin
      if (fin.tag.clamp) begin
        tdata_next[32*l +: 32] = fin.tag.neg[l] ? (~fin.quo[l] + 32'd1) : fin.quo[l];
      end else begin
        tdata_next[32*l +: 32] = fin.tag.raw[l];
      end
    end
    tdata_next[126:96] = fin.tag.clamp ? 31'd0 : fin.root[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      m_axis_tvalid <= fin.tag.vld;
      m_axis_tdata  <= tdata_next;
      m_axis_tuser  <= fin.tag.clamp;
    end
  end

  `QWC_ASSERT_IMPL(a_clamp_w_zero, clk, rst, m_axis_tvalid && m_axis_tuser,
                   m_axis_tdata[126:96] == 31'd0)
  `QWC_ASSERT_IMPL(a_w_bound, clk, rst, m_axis_tvalid && !m_axis_tuser,
                   64'(m_axis_tdata[126:96]) <= One)
  `QWC_ASSERT_IMPL(a_root_clamp, clk, rst, sq[SqrtCells].tag.vld && sq[SqrtCells].tag.clamp,
                   ({32'd0, sq[SqrtCells].root} << FRAC_BITS) >= One)
  `QWC_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule
`default_nettype wire
